// File: rtl/r2yc_pkg.sv
package r2yc_pkg;

	// Payload widths
	localparam int BYTE_W   = 8;
	localparam int SAMPLE_W = 8;

	// Default sizing handed to the top level
	localparam int DEF_MAX_WIDTH     = 2048;
	localparam int DEF_MAX_HEIGHT    = 4096;
	localparam int DEF_FRACTION_BITS = 16;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 13;
	localparam int PPL_W       = 12;
	localparam int LPF_W       = 13;
	localparam int POS_W       = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEGACY_COEF = 3'd0,
		REG_PIXELS_PER_LINE = 3'd1,
		REG_LINES_PER_FRAME = 3'd2,
		REG_RED_POSITION = 3'd3,
		REG_GREEN_POSITION = 3'd4,
		REG_BLUE_POSITION = 3'd5
	} cfg_index_t;

	typedef struct packed {
		logic             legacy;
		logic [PPL_W-1:0] ppl;
		logic [LPF_W-1:0] lpf;
		logic [POS_W-1:0] red_pos;
		logic [POS_W-1:0] green_pos;
		logic [POS_W-1:0] blue_pos;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		legacy: 1'b1,
		ppl: 12'd640,
		lpf: 13'd480,
		red_pos: 2'd0,
		green_pos: 2'd1,
		blue_pos: 2'd2
	};

endpackage

// File: rtl/r2yc_pixel_if.sv
interface r2yc_pixel_if;
	logic                          valid;
	logic                          ready;
	logic [r2yc_pkg::BYTE_W-1:0]   pixel_byte_0;
	logic [r2yc_pkg::BYTE_W-1:0]   pixel_byte_1;
	logic [r2yc_pkg::BYTE_W-1:0]   pixel_byte_2;
	logic [r2yc_pkg::BYTE_W-1:0]   pixel_byte_3;

	modport source (
		output valid, pixel_byte_0, pixel_byte_1, pixel_byte_2, pixel_byte_3,
		input  ready
	);
	modport sink (
		input  valid, pixel_byte_0, pixel_byte_1, pixel_byte_2, pixel_byte_3,
		output ready
	);
endinterface

// File: rtl/r2yc_chroma_if.sv
interface r2yc_chroma_if;
	logic                          valid;
	logic                          ready;
	logic [r2yc_pkg::SAMPLE_W-1:0] u_sample;
	logic [r2yc_pkg::SAMPLE_W-1:0] v_sample;
	logic                          frame_end;

	modport source (
		output valid, u_sample, v_sample, frame_end,
		input  ready
	);
	modport sink (
		input  valid, u_sample, v_sample, frame_end,
		output ready
	);
endinterface

// File: rtl/r2yc_ram.sv
module r2yc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port, registered read port that holds when not enabled
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/rgb_to_yuv420_chroma.sv
// Channel   Dir  Payload                                      Transfer
// pixel     in   pixel_byte_0..3 (8 b each)                   valid & ready
// chroma    out  u_sample, v_sample (8 b), frame_end (1 b)    valid & ready
// cfg       in   cfg_index (3 b), cfg_data (13 b)             cfg_wr_en
//
// One pixel per cycle sustained unless a stalled output fills every stage; a result
// leaves through the pixel product, 2x2 sum and output registers after its last pixel.
// The line store is read when an odd-column, odd-row pixel transfers and written with a
// pair sum as an odd-column, even-row pixel leaves the product stage, on separate ports.
// Reset sets default config, clears counters and the pending pair sum, not the line store.
// A stalled output backs up stage by stage; pixel ready drops only when every stage is full.
module rgb_to_yuv420_chroma #(
	parameter int MAX_WIDTH     = r2yc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = r2yc_pkg::DEF_MAX_HEIGHT,
	parameter int FRACTION_BITS = r2yc_pkg::DEF_FRACTION_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	r2yc_pixel_if.sink                       pixel,
	r2yc_chroma_if.source                    chroma,
	input  logic                             cfg_wr_en,
	input  logic [r2yc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [r2yc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Counter and dimension widths
	localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW    = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int PAIRS = MAX_WIDTH / 2;
	localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

	// Arithmetic widths: coefficient, pixel value, pair sum, block sum, offset sum, quotient
	localparam int CFW = FRACTION_BITS + 1;
	localparam int PW  = FRACTION_BITS + 10;
	localparam int SW  = PW + 1;
	localparam int TW  = PW + 2;
	localparam int FW  = TW + 1;
	localparam int QW  = FW - (FRACTION_BITS + 2);

	// Coefficient magnitudes, k/1000 scaled and rounded
	localparam int SCALE = 2 ** FRACTION_BITS;
	localparam int K169 = (169 * SCALE + 500) / 1000;
	localparam int K331 = (331 * SCALE + 500) / 1000;
	localparam int K500 = (500 * SCALE + 500) / 1000;
	localparam int K419 = (419 * SCALE + 500) / 1000;
	localparam int K081 = (81 * SCALE + 500) / 1000;
	localparam int K147 = (147 * SCALE + 500) / 1000;
	localparam int K289 = (289 * SCALE + 500) / 1000;
	localparam int K436 = (436 * SCALE + 500) / 1000;
	localparam int K615 = (615 * SCALE + 500) / 1000;
	localparam int K515 = (515 * SCALE + 500) / 1000;
	localparam int K100 = (100 * SCALE + 500) / 1000;

	localparam logic signed [FW-1:0] OFFSET = FW'(128 * (2 ** (FRACTION_BITS + 2)));
	localparam logic signed [FW-1:0] HALF   = FW'(2 ** (FRACTION_BITS + 1));

	// Round, offset and clamp one block sum
	function automatic logic [r2yc_pkg::SAMPLE_W-1:0] finish_sample(
		input logic signed [TW-1:0] sum
	);
		logic signed [FW-1:0] t;
		logic signed [FW-1:0] tr;
		logic [QW-1:0]        q;
		t  = FW'(sum) + OFFSET;
		tr = t + HALF;
		q  = tr[FW-1:FRACTION_BITS+2];
		if (t <= 0) begin
			finish_sample = '0;
		end else if (q > QW'(255)) begin
			finish_sample = 8'hFF;
		end else begin
			finish_sample = q[r2yc_pkg::SAMPLE_W-1:0];
		end
	endfunction

	r2yc_pkg::cfg_t cfg_q;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic signed [PW-1:0] pend_u_q;
	logic signed [PW-1:0] pend_v_q;

	logic                 s1_valid_q;
	logic signed [PW-1:0] pu_s1;
	logic signed [PW-1:0] pv_s1;
	logic                 act_s1;
	logic                 odd_col_s1;
	logic                 odd_row_s1;
	logic                 last_s1;
	logic [AW-1:0]        idx_s1;

	logic                 s2_valid_q;
	logic signed [TW-1:0] tot_u_s2;
	logic signed [TW-1:0] tot_v_s2;
	logic                 last_s2;

	logic                              out_valid_q;
	logic [r2yc_pkg::SAMPLE_W-1:0]     u_q;
	logic [r2yc_pkg::SAMPLE_W-1:0]     v_q;
	logic                              frame_end_q;

	logic in_xfer;
	logic out_take;
	logic s2_ready;
	logic s2_adv;
	logic s1_adv;
	logic s1_emit;

	logic [WW-1:0] w_eff;
	logic [WW-1:0] w_even;
	logic [HW-1:0] h_eff;
	logic [HW-1:0] h_even;
	logic          act_in;
	logic          col_wrap;
	logic          row_wrap;

	logic [r2yc_pkg::BYTE_W-1:0] bytes [4];
	logic [r2yc_pkg::BYTE_W-1:0] red;
	logic [r2yc_pkg::BYTE_W-1:0] green;
	logic [r2yc_pkg::BYTE_W-1:0] blue;
	logic signed [CFW-1:0] cu_r, cu_g, cu_b, cv_r, cv_g, cv_b;
	logic signed [PW-1:0]  pu_in;
	logic signed [PW-1:0]  pv_in;

	logic signed [SW-1:0]  su;
	logic signed [SW-1:0]  sv;
	logic [2*SW-1:0]       rd_word;
	logic signed [SW-1:0]  st_u;
	logic signed [SW-1:0]  st_v;
	logic                  ram_we;
	logic                  ram_re;

	// Handshake chain: each stage takes when empty or when it moves on
	assign out_take   = !out_valid_q || chroma.ready;
	assign s2_adv     = s2_valid_q && out_take;
	assign s2_ready   = !s2_valid_q || out_take;
	assign s1_adv     = s1_valid_q && s2_ready;
	assign pixel.ready = !s1_valid_q || s2_ready;
	assign in_xfer    = pixel.valid && pixel.ready;
	assign s1_emit    = act_s1 && odd_col_s1 && odd_row_s1;

	// Effective frame size, limited to the supported range
	always_comb begin
		if (32'(cfg_q.ppl) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else if (cfg_q.ppl < 12'd2) begin
			w_eff = WW'(2);
		end else begin
			w_eff = WW'(cfg_q.ppl);
		end
		if (32'(cfg_q.lpf) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else if (cfg_q.lpf < 13'd2) begin
			h_eff = HW'(2);
		end else begin
			h_eff = HW'(cfg_q.lpf);
		end
		w_even   = {w_eff[WW-1:1], 1'b0};
		h_even   = {h_eff[HW-1:1], 1'b0};
		act_in   = (WW'(col_q) < w_even) && (HW'(row_q) < h_even);
		col_wrap = WW'(col_q) >= w_eff - WW'(1);
		row_wrap = HW'(row_q) >= h_eff - HW'(1);
	end

	// Pick color bytes and coefficient set
	assign bytes[0] = pixel.pixel_byte_0;
	assign bytes[1] = pixel.pixel_byte_1;
	assign bytes[2] = pixel.pixel_byte_2;
	assign bytes[3] = pixel.pixel_byte_3;
	assign red      = bytes[cfg_q.red_pos];
	assign green    = bytes[cfg_q.green_pos];
	assign blue     = bytes[cfg_q.blue_pos];

	always_comb begin
		if (cfg_q.legacy) begin
			cu_r = -CFW'(K169);
			cu_g = -CFW'(K331);
			cu_b = CFW'(K500);
			cv_r = CFW'(K500);
			cv_g = -CFW'(K419);
			cv_b = -CFW'(K081);
		end else begin
			cu_r = -CFW'(K147);
			cu_g = -CFW'(K289);
			cu_b = CFW'(K436);
			cv_r = CFW'(K615);
			cv_g = -CFW'(K515);
			cv_b = -CFW'(K100);
		end
	end

	// Per-pixel chroma products
	always_comb begin
		pu_in = PW'(cu_r) * PW'(signed'({1'b0, red}))
			+ PW'(cu_g) * PW'(signed'({1'b0, green}))
			+ PW'(cu_b) * PW'(signed'({1'b0, blue}));
		pv_in = PW'(cv_r) * PW'(signed'({1'b0, red}))
			+ PW'(cv_g) * PW'(signed'({1'b0, green}))
			+ PW'(cv_b) * PW'(signed'({1'b0, blue}));
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= r2yc_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (r2yc_pkg::cfg_index_t'(cfg_index))
				r2yc_pkg::REG_LEGACY_COEF: cfg_q.legacy <= cfg_data[0];
				r2yc_pkg::REG_PIXELS_PER_LINE: cfg_q.ppl <= cfg_data[r2yc_pkg::PPL_W-1:0];
				r2yc_pkg::REG_LINES_PER_FRAME: cfg_q.lpf <= cfg_data[r2yc_pkg::LPF_W-1:0];
				r2yc_pkg::REG_RED_POSITION: cfg_q.red_pos <= cfg_data[r2yc_pkg::POS_W-1:0];
				r2yc_pkg::REG_GREEN_POSITION: cfg_q.green_pos <= cfg_data[r2yc_pkg::POS_W-1:0];
				r2yc_pkg::REG_BLUE_POSITION: cfg_q.blue_pos <= cfg_data[r2yc_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance raster position on every pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage 1: products and position flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= in_xfer || (s1_valid_q && !s1_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pu_s1      <= pu_in;
			pv_s1      <= pv_in;
			act_s1     <= act_in;
			odd_col_s1 <= col_q[0];
			odd_row_s1 <= row_q[0];
			last_s1    <= (WW'(col_q) == w_even - WW'(1))
				&& (HW'(row_q) == h_even - HW'(1));
			idx_s1     <= AW'(col_q >> 1);
		end
	end

	// Line store: read at transfer, write even-row pair sums from stage 1
	assign ram_re = in_xfer && act_in && col_q[0] && row_q[0];
	assign ram_we = s1_adv && act_s1 && odd_col_s1 && !odd_row_s1;
	assign su     = SW'(pend_u_q) + SW'(pu_s1);
	assign sv     = SW'(pend_v_q) + SW'(pv_s1);
	assign st_u   = rd_word[2*SW-1:SW];
	assign st_v   = rd_word[SW-1:0];

	r2yc_ram #(
		.WIDTH(2 * SW),
		.DEPTH(PAIRS)
	) u_line_store (
		.clk(clk),
		.wr_en(ram_we),
		.wr_addr(idx_s1),
		.wr_data({su, sv}),
		.rd_en(ram_re),
		.rd_addr(AW'(col_q >> 1)),
		.rd_data(rd_word)
	);

	// Hold first pixel of each column pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_u_q <= '0;
			pend_v_q <= '0;
		end else if (s1_adv && act_s1 && !odd_col_s1) begin
			pend_u_q <= pu_s1;
			pend_v_q <= pv_s1;
		end
	end

	// Stage 2: complete 2x2 block sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else begin
			s2_valid_q <= (s1_adv && s1_emit) || (s2_valid_q && !s2_adv);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_emit) begin
			tot_u_s2 <= TW'(st_u) + TW'(su);
			tot_v_s2 <= TW'(st_v) + TW'(sv);
			last_s2  <= last_s1;
		end
	end

	// Output register: round and clamp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= s2_adv || (out_valid_q && !chroma.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			u_q         <= finish_sample(tot_u_s2);
			v_q         <= finish_sample(tot_v_s2);
			frame_end_q <= last_s2;
		end
	end

	assign chroma.valid     = out_valid_q;
	assign chroma.u_sample  = u_q;
	assign chroma.v_sample  = v_q;
	assign chroma.frame_end = frame_end_q;

`ifndef SYNTHESIS
	a_store_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re && (idx_s1 == AW'(col_q >> 1))))
		else $error("line store read and write hit the same pair");

	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> s1_valid_q)
		else $error("transferred pixel missing from stage 1");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_q && !s2_adv) |=> (s2_valid_q && $stable(tot_u_s2) && $stable(tot_v_s2)))
		else $error("stalled block sum changed");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !chroma.ready) |=> $stable(u_q) && $stable(frame_end_q))
		else $error("stalled result changed");
`endif

endmodule

// File: tb/sv/rgb_to_yuv420_chroma_tb.sv
`timescale 1ns / 100ps

module rgb_to_yuv420_chroma_tb;

	localparam int          FB            = r2yc_pkg::DEF_FRACTION_BITS;
	localparam int          PAIR_SLOTS    = r2yc_pkg::DEF_MAX_WIDTH / 2;
	localparam int          DRAIN_CYCLES  = 12;
	localparam int          RANDOM_PIXELS = 560;
	localparam int          TAIL_LIMIT    = 100000;
	localparam longint      TIMEOUT_NS    = 64'd60_000_000;

	typedef logic [3:0][r2yc_pkg::BYTE_W-1:0] pixel_t;

	typedef struct packed {
		logic [r2yc_pkg::SAMPLE_W-1:0] u_sample;
		logic [r2yc_pkg::SAMPLE_W-1:0] v_sample;
		logic                          frame_end;
	} chroma_t;

	typedef struct {
		bit                              is_write;
		r2yc_pkg::cfg_index_t            reg_sel;
		logic [r2yc_pkg::CFG_DATA_W-1:0] reg_val;
		pixel_t                          px;
		bit                              pinned;
		chroma_t                         pinned_out;
	} step_t;

	logic                             clk;
	logic                             arst_n;
	logic                             cfg_wr_en;
	logic [r2yc_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [r2yc_pkg::CFG_DATA_W-1:0]  cfg_data;

	r2yc_pixel_if  pixel_bus ();
	r2yc_chroma_if chroma_bus ();

	rgb_to_yuv420_chroma i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel_bus),
		.chroma    (chroma_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Chroma predictor state: configuration, line store of pair sums, counters
	r2yc_pkg::cfg_t cfg_model;
	longint      line_u [PAIR_SLOTS];
	longint      line_v [PAIR_SLOTS];
	longint      first_u;
	longint      first_v;
	int unsigned col_at;
	int unsigned row_at;

	chroma_t     expected_chroma [$];
	step_t       directed [$];
	bit          quiet;
	int          failures;
	int          pixels_sent;
	int          pairs_checked;
	int          settings_used;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Give up after a generous bound
	initial begin
		#(TIMEOUT_NS);
		$display("[rgb_to_yuv420_chroma] ERROR");
		$finish;
	end

	// Mostly no gap, some short ones, a few long ones; none in quiet phases
	function automatic int idle_cycles();
		int pick;
		if (quiet)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [r2yc_pkg::BYTE_W-1:0] any_byte();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return r2yc_pkg::BYTE_W'($urandom);
		endcase
	endfunction

	function automatic pixel_t any_pixel();
		return {any_byte(), any_byte(), any_byte(), any_byte()};
	endfunction

	// Coefficient k/1000 in FB fractional bits, rounded to nearest
	function automatic longint scaled(int k);
		longint mag;
		mag = (k < 0) ? -k : k;
		mag = (mag * (longint'(1) <<< FB) + 500) / 1000;
		return (k < 0) ? -mag : mag;
	endfunction

	function automatic longint weigh(int kr, int kg, int kb, longint r, longint g, longint b);
		return scaled(kr) * r + scaled(kg) * g + scaled(kb) * b;
	endfunction

	// Offset by 128, round half away from zero, clamp to the sample range
	function automatic logic [r2yc_pkg::SAMPLE_W-1:0] to_sample(longint block_sum);
		longint t;
		longint q;
		t = (longint'(128) <<< (FB + 2)) + block_sum;
		if (t <= 0)
			return '0;
		q = (t + (longint'(1) <<< (FB + 1))) >>> (FB + 2);
		return (q > 255) ? 8'd255 : q[r2yc_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic int unsigned bound_dim(int unsigned v, int unsigned hi);
		if (v < 2)
			return 2;
		return (v > hi) ? hi : v;
	endfunction

	// Advance the predictor by one pixel; return 1 when a chroma pair is due
	function automatic bit predict_chroma(input pixel_t px, output chroma_t pair);
		int unsigned w;
		int unsigned h;
		int unsigned w_even;
		int unsigned h_even;
		int unsigned slot;
		longint      r;
		longint      g;
		longint      b;
		longint      pu;
		longint      pv;
		longint      su;
		longint      sv;
		bit          fired;
		fired = 1'b0;
		pair = '0;
		w = bound_dim(cfg_model.ppl, r2yc_pkg::DEF_MAX_WIDTH);
		h = bound_dim(cfg_model.lpf, r2yc_pkg::DEF_MAX_HEIGHT);
		w_even = w - (w % 2);
		h_even = h - (h % 2);
		r = px[cfg_model.red_pos];
		g = px[cfg_model.green_pos];
		b = px[cfg_model.blue_pos];
		if (cfg_model.legacy) begin
			pu = weigh(-169, -331, 500, r, g, b);
			pv = weigh(500, -419, -81, r, g, b);
		end else begin
			pu = weigh(-147, -289, 436, r, g, b);
			pv = weigh(615, -515, -100, r, g, b);
		end
		// Even column: hold; odd column: store on even rows, finish on odd rows
		if (col_at < w_even && row_at < h_even) begin
			if (col_at % 2 == 0) begin
				first_u = pu;
				first_v = pv;
			end else begin
				slot = (col_at / 2) % PAIR_SLOTS;
				su = first_u + pu;
				sv = first_v + pv;
				if (row_at % 2 == 0) begin
					line_u[slot] = su;
					line_v[slot] = sv;
				end else begin
					pair.u_sample  = to_sample(line_u[slot] + su);
					pair.v_sample  = to_sample(line_v[slot] + sv);
					pair.frame_end = (row_at == h_even - 1) && (col_at == w_even - 1);
					fired = 1'b1;
				end
			end
		end
		// Advance the raster position; a counter past the end wraps
		if (col_at >= w - 1) begin
			col_at = 0;
			row_at = (row_at >= h - 1) ? 0 : row_at + 1;
		end else begin
			col_at = col_at + 1;
		end
		return fired;
	endfunction

	function automatic void add_write(r2yc_pkg::cfg_index_t sel, int unsigned val);
		step_t s;
		s = '{reg_sel: r2yc_pkg::REG_LEGACY_COEF, default: '0};
		s.is_write = 1'b1;
		s.reg_sel  = sel;
		s.reg_val  = r2yc_pkg::CFG_DATA_W'(val);
		directed.push_back(s);
	endfunction

	function automatic void add_pixel(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3);
		step_t s;
		s = '{reg_sel: r2yc_pkg::REG_LEGACY_COEF, default: '0};
		s.px = {b3, b2, b1, b0};
		directed.push_back(s);
	endfunction

	function automatic void add_pinned(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3, logic [7:0] u, logic [7:0] v, logic fe);
		step_t s;
		s = '{reg_sel: r2yc_pkg::REG_LEGACY_COEF, default: '0};
		s.px         = {b3, b2, b1, b0};
		s.pinned     = 1'b1;
		s.pinned_out = {u, v, fe};
		directed.push_back(s);
	endfunction

	// Let every outstanding result leave and the pipeline empty out
	task automatic drain_pipeline();
		pixel_bus.valid <= 1'b0;
		while (expected_chroma.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input r2yc_pkg::cfg_index_t sel,
			input logic [r2yc_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (sel)
			r2yc_pkg::REG_LEGACY_COEF:     cfg_model.legacy    = val[0];
			r2yc_pkg::REG_PIXELS_PER_LINE: cfg_model.ppl       = val[r2yc_pkg::PPL_W-1:0];
			r2yc_pkg::REG_LINES_PER_FRAME: cfg_model.lpf       = val[r2yc_pkg::LPF_W-1:0];
			r2yc_pkg::REG_RED_POSITION:    cfg_model.red_pos   = val[r2yc_pkg::POS_W-1:0];
			r2yc_pkg::REG_GREEN_POSITION:  cfg_model.green_pos = val[r2yc_pkg::POS_W-1:0];
			r2yc_pkg::REG_BLUE_POSITION:   cfg_model.blue_pos  = val[r2yc_pkg::POS_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one pixel after a random gap and record what it should produce
	task automatic send_pixel(input pixel_t px, input bit pinned, input chroma_t pinned_out);
		int      gap;
		chroma_t pair;
		gap = idle_cycles();
		if (gap > 0) begin
			pixel_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_bus.valid        <= 1'b1;
		pixel_bus.pixel_byte_0 <= px[0];
		pixel_bus.pixel_byte_1 <= px[1];
		pixel_bus.pixel_byte_2 <= px[2];
		pixel_bus.pixel_byte_3 <= px[3];
		@(posedge clk);
		while (!pixel_bus.ready)
			@(posedge clk);
		pixels_sent++;
		if (predict_chroma(px, pair))
			expected_chroma.push_back(pinned ? pinned_out : pair);
	endtask

	// Configure a frame size with random format and coefficients, then send whole frames
	task automatic run_frames(input int unsigned ppl, input int unsigned lpf,
			input int frames);
		int n;
		int i;
		drain_pipeline();
		quiet = ($urandom_range(0, 3) == 0);
		write_reg(r2yc_pkg::REG_LEGACY_COEF, r2yc_pkg::CFG_DATA_W'($urandom_range(0, 1)));
		write_reg(r2yc_pkg::REG_PIXELS_PER_LINE, r2yc_pkg::CFG_DATA_W'(ppl));
		write_reg(r2yc_pkg::REG_LINES_PER_FRAME, r2yc_pkg::CFG_DATA_W'(lpf));
		write_reg(r2yc_pkg::REG_RED_POSITION, r2yc_pkg::CFG_DATA_W'($urandom_range(0, 3)));
		write_reg(r2yc_pkg::REG_GREEN_POSITION, r2yc_pkg::CFG_DATA_W'($urandom_range(0, 3)));
		write_reg(r2yc_pkg::REG_BLUE_POSITION, r2yc_pkg::CFG_DATA_W'($urandom_range(0, 3)));
		settings_used++;
		n = frames * bound_dim(cfg_model.ppl, r2yc_pkg::DEF_MAX_WIDTH)
			* bound_dim(cfg_model.lpf, r2yc_pkg::DEF_MAX_HEIGHT);
		for (i = 0; i < n; i++)
			send_pixel(any_pixel(), 1'b0, '0);
	endtask

	// Receive side: random stalls, none in quiet phases
	initial begin
		int hold;
		hold = 0;
		chroma_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold = hold - 1;
				chroma_bus.ready <= 1'b0;
			end else begin
				chroma_bus.ready <= 1'b1;
				hold = idle_cycles();
			end
		end
	end

	// Compare each chroma transfer with the oldest expected pair
	always @(posedge clk) begin : check_pair
		chroma_t want;
		if (arst_n && chroma_bus.valid && chroma_bus.ready) begin
			pairs_checked++;
			if (expected_chroma.size() == 0) begin
				$error("unexpected chroma pair: u_sample %0d v_sample %0d frame_end %0d",
					chroma_bus.u_sample, chroma_bus.v_sample, chroma_bus.frame_end);
				failures++;
			end else begin
				want = expected_chroma.pop_front();
				if (chroma_bus.u_sample !== want.u_sample) begin
					$error("u_sample: expected %0d, got %0d", want.u_sample,
						chroma_bus.u_sample);
					failures++;
				end
				if (chroma_bus.v_sample !== want.v_sample) begin
					$error("v_sample: expected %0d, got %0d", want.v_sample,
						chroma_bus.v_sample);
					failures++;
				end
				if (chroma_bus.frame_end !== want.frame_end) begin
					$error("frame_end: expected %0d, got %0d", want.frame_end,
						chroma_bus.frame_end);
					failures++;
				end
			end
		end
	end

	initial begin
		int start;
		int tail;
		int ppl;
		int lpf;
		failures      = 0;
		pixels_sent   = 0;
		pairs_checked = 0;
		settings_used = 1;
		quiet         = 1'b0;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		pixel_bus.valid        = 1'b0;
		pixel_bus.pixel_byte_0 = '0;
		pixel_bus.pixel_byte_1 = '0;
		pixel_bus.pixel_byte_2 = '0;
		pixel_bus.pixel_byte_3 = '0;
		cfg_model = r2yc_pkg::CFG_RESET;
		first_u   = 0;
		first_v   = 0;
		col_at    = 0;
		row_at    = 0;

		// Reset defaults, two-pixel lines: white and black both land on 128
		add_write(r2yc_pkg::REG_PIXELS_PER_LINE, 2);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		add_pinned(8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd128, 8'd128, 1'b0);
		add_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		add_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		add_pixel(8'h00, 8'h00, 8'h00, 8'hFF);
		add_pinned(8'h00, 8'h00, 8'h00, 8'hFF, 8'd128, 8'd128, 1'b0);
		// Shrink the height mid-frame: the row counter is past the end and wraps
		add_write(r2yc_pkg::REG_LINES_PER_FRAME, 2);
		add_pixel(8'h3C, 8'hC3, 8'h5A, 8'hA5);
		add_pixel(8'hC3, 8'h3C, 8'hA5, 8'h5A);
		// Other set, moved byte positions, odd width and height
		add_write(r2yc_pkg::REG_LEGACY_COEF, 0);
		add_write(r2yc_pkg::REG_RED_POSITION, 3);
		add_write(r2yc_pkg::REG_GREEN_POSITION, 0);
		add_write(r2yc_pkg::REG_BLUE_POSITION, 1);
		add_write(r2yc_pkg::REG_PIXELS_PER_LINE, 3);
		add_write(r2yc_pkg::REG_LINES_PER_FRAME, 3);
		add_pixel(8'hFF, 8'hFF, 8'h5A, 8'h00);
		add_pixel(8'hFF, 8'hFF, 8'hA5, 8'h00);
		add_pixel(8'h12, 8'h34, 8'h56, 8'h78);
		add_pixel(8'hFF, 8'hFF, 8'h00, 8'h00);
		add_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
		add_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0);
		add_pixel(8'h01, 8'h80, 8'h7F, 8'hFE);
		add_pixel(8'hFE, 8'h7F, 8'h80, 8'h01);
		add_pixel(8'h55, 8'hAA, 8'h55, 8'hAA);
		// Sizes below range clamp to 2x2; gray from the fourth byte gives 128
		add_write(r2yc_pkg::REG_PIXELS_PER_LINE, 0);
		add_write(r2yc_pkg::REG_LINES_PER_FRAME, 1);
		add_write(r2yc_pkg::REG_RED_POSITION, 3);
		add_write(r2yc_pkg::REG_GREEN_POSITION, 3);
		add_write(r2yc_pkg::REG_BLUE_POSITION, 3);
		add_pixel(8'h00, 8'hFF, 8'h12, 8'hC8);
		add_pixel(8'h00, 8'hFF, 8'h12, 8'hC8);
		add_pixel(8'h00, 8'hFF, 8'h12, 8'hC8);
		add_pinned(8'h00, 8'hFF, 8'h12, 8'hC8, 8'd128, 8'd128, 1'b1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed steps
		foreach (directed[i]) begin
			if (directed[i].is_write) begin
				drain_pipeline();
				write_reg(directed[i].reg_sel, directed[i].reg_val);
			end else begin
				send_pixel(directed[i].px, directed[i].pinned, directed[i].pinned_out);
			end
		end

		// Small random frames with random format
		start = pixels_sent;
		while (pixels_sent - start < RANDOM_PIXELS) begin
			case ($urandom_range(0, 9))
				0: ppl = $urandom_range(0, 1);
				1: ppl = $urandom_range(17, 48);
				default: ppl = $urandom_range(2, 16);
			endcase
			case ($urandom_range(0, 9))
				0: lpf = $urandom_range(0, 1);
				default: lpf = $urandom_range(2, 8);
			endcase
			run_frames(ppl, lpf, $urandom_range(1, 2));
		end

		// Wait for the last results, bounded
		pixel_bus.valid <= 1'b0;
		tail = 0;
		while (expected_chroma.size() != 0 && tail < TAIL_LIMIT) begin
			@(posedge clk);
			tail++;
		end
		if (expected_chroma.size() != 0) begin
			$error("%0d expected chroma pairs never arrived", expected_chroma.size());
			failures++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels over %0d frame settings, checked %0d chroma pairs",
			pixels_sent, settings_used, pairs_checked);
		if (failures == 0)
			$display("[rgb_to_yuv420_chroma] OK");
		else
			$display("[rgb_to_yuv420_chroma] ERROR");
		$finish;
	end

endmodule

// File: files.f
rtl/r2yc_pkg.sv
rtl/r2yc_pixel_if.sv
rtl/r2yc_chroma_if.sv
rtl/r2yc_ram.sv
rtl/rgb_to_yuv420_chroma.sv
tb/sv/rgb_to_yuv420_chroma_tb.sv
